@@ hw/rtl/tla_pkg.sv @@
package tla_pkg;

    // ASCII codes used by the annotator
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_CAP_I  = 8'h49;
    localparam logic [7:0] CH_CAP_M  = 8'h4D;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_DEL    = 8'd127;
    localparam logic [7:0] CTRL_OFS  = 8'd64;
    localparam logic [7:0] META_OFS  = 8'd128;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_NUMBER_MODE      = 3'd0,
        CFG_SQUEEZE_BLANK    = 3'd1,
        CFG_SHOW_ENDS        = 3'd2,
        CFG_SHOW_TABS        = 3'd3,
        CFG_SHOW_NONPRINTING = 3'd4
    } t_cfg_reg;

    localparam logic [1:0] NUM_OFF     = 2'd0;
    localparam logic [1:0] NUM_ALL     = 2'd1;

    // escape prefix in front of the final character
    typedef enum logic [1:0] {
        ESC_NONE       = 2'd0,   // nothing
        ESC_CARET      = 2'd1,   // ^
        ESC_META       = 2'd2,   // M-
        ESC_META_CARET = 2'd3    // M-^
    } t_esc;

endpackage

@@ hw/rtl/tla_in_if.sv @@
interface tla_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

@@ hw/rtl/tla_out_if.sv @@
interface tla_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink (input valid, input out_byte, input last, output ready);
endinterface

@@ hw/rtl/text_line_annotator.sv @@
// Channel   | Dir | Word                  | Notes
// i_in      | in  | in_byte[7:0]          | one raw text byte per word
// o_out     | out | out_byte[7:0], last   | annotated bytes, last marks end of a run
// i_cfg_*   | in  | addr[2:0], wdata[1:0] | register write, no read-back
//
// Each input byte expands to 0..NUMBER_DIGITS+5 output bytes, emitted one per cycle
// from an item register while o_out does not stall; an input is taken in the cycle
// its item's last byte leaves, so a multi-byte item holds the input until that last
// byte leaves (single-byte items: full rate). Accepted bytes pass the item register,
// then the output register. Squeezed newlines are accepted and produce no output.
// Reset is synchronous, active low; a stall on o_out holds the item and the input.
module text_line_annotator #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tla_in_if.sink                         i_in,
    tla_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [tla_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [tla_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int BW = 4 * NUMBER_DIGITS;
    localparam int NT = NUMBER_DIGITS + 1;          // digits plus tab
    localparam int PW = $clog2(NUMBER_DIGITS + 6);
    localparam int TW = $clog2(NT);

    // configuration
    logic [1:0] r_num_mode;
    logic       r_squeeze, r_ends, r_tabs, r_nonprint;

    // stream state
    logic [7:0]    r_prev;
    logic          r_start;
    logic [1:0]    r_blank;
    logic [BW-1:0] r_line;

    // item register
    logic          r_it_vld;
    logic [PW-1:0] r_pos, r_dpos, r_ppos, r_cpos;
    logic [7:0]    r_txt [NT];
    tla_pkg::t_esc r_esc;
    logic [7:0]    r_ch;

    // output register
    logic       r_ov, r_ol;
    logic [7:0] r_ob;

    logic          in_fire, adv, it_last;
    logic [7:0]    ch, fch, sel_byte;
    logic          line_start, squeeze_hit, emit, do_num, dollar;
    logic [1:0]    n_blank, plen, ridx;
    tla_pkg::t_esc esc;
    logic [BW-1:0] n_line, nines;
    logic [7:0]    n_txt [NT];
    logic [PW-1:0] n_dpos, n_ppos, n_cpos;

    assign ch      = i_in.in_byte;
    assign it_last = (r_pos == r_cpos);
    assign adv     = r_it_vld && (!r_ov || o_out.ready);
    assign i_in.ready = !r_it_vld || (adv && it_last);
    assign in_fire = i_in.valid && i_in.ready;

    always_comb begin
        line_start  = r_start || (r_prev == tla_pkg::CH_LF);
        squeeze_hit = r_squeeze && (ch == tla_pkg::CH_LF) && line_start;
        if (squeeze_hit) begin
            n_blank = (r_blank == 2'd2) ? 2'd2 : r_blank + 2'd1;
        end else begin
            n_blank = 2'd0;
        end
        emit   = (n_blank <= 2'd1);
        // mode 2 and 3 both number nonblank lines only
        do_num = emit && line_start && ((r_num_mode == tla_pkg::NUM_ALL) ||
                 (r_num_mode[1] && (ch != tla_pkg::CH_LF)));
        dollar = r_ends && (ch == tla_pkg::CH_LF);
    end

    // escape classification
    always_comb begin
        esc = tla_pkg::ESC_NONE;
        fch = ch;
        if (r_tabs && (ch == tla_pkg::CH_TAB)) begin
            esc = tla_pkg::ESC_CARET;
            fch = tla_pkg::CH_CAP_I;
        end else if (r_nonprint) begin
            if (ch inside {[8'd0:8'd8], [8'd11:8'd31]}) begin
                esc = tla_pkg::ESC_CARET;
                fch = ch + tla_pkg::CTRL_OFS;
            end else if (ch == tla_pkg::CH_DEL) begin
                esc = tla_pkg::ESC_CARET;
                fch = tla_pkg::CH_QMARK;
            end else if (ch inside {[8'd128:8'd159]}) begin
                esc = tla_pkg::ESC_META_CARET;
                fch = ch - tla_pkg::CTRL_OFS;
            end else if (ch inside {[8'd160:8'd254]}) begin
                esc = tla_pkg::ESC_META;
                fch = ch - tla_pkg::META_OFS;
            end else if (ch == 8'd255) begin
                esc = tla_pkg::ESC_META_CARET;
                fch = tla_pkg::CH_QMARK;
            end
        end
        case (esc)
            tla_pkg::ESC_NONE:       plen = 2'd0;
            tla_pkg::ESC_CARET:      plen = 2'd1;
            tla_pkg::ESC_META:       plen = 2'd2;
            tla_pkg::ESC_META_CARET: plen = 2'd3;
            default:                 plen = 2'd0;
        endcase
        n_dpos = do_num ? PW'(NT) : '0;
        n_ppos = n_dpos + PW'(dollar);
        n_cpos = n_ppos + PW'(plen);
    end

    // number text and BCD increment, saturating at all nines
    always_comb begin
        logic       leading;
        logic       carry;
        logic [3:0] dig;
        leading = 1'b1;
        carry   = 1'b1;
        nines   = '0;
        n_line  = r_line;
        for (int p = 0; p < NUMBER_DIGITS; p++) begin
            dig = r_line[4*(NUMBER_DIGITS-1-p) +: 4];
            if (leading && (dig == 4'd0) && (p < NUMBER_DIGITS - 1)) begin
                n_txt[p] = tla_pkg::CH_SPACE;
            end else begin
                leading  = 1'b0;
                n_txt[p] = tla_pkg::CH_ZERO + {4'h0, (dig > 4'd9) ? 4'd9 : dig};
            end
        end
        n_txt[NUMBER_DIGITS] = tla_pkg::CH_TAB;
        for (int d = 0; d < NUMBER_DIGITS; d++) begin
            nines[4*d +: 4] = 4'd9;
            dig = r_line[4*d +: 4];
            if (carry) begin
                if (dig >= 4'd9) begin
                    n_line[4*d +: 4] = 4'd0;
                end else begin
                    n_line[4*d +: 4] = dig + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        if (r_line == nines) begin
            n_line = r_line;
        end
    end

    // byte at the current position of the item
    always_comb begin
        ridx = 2'(r_pos - r_ppos);
        if (r_pos < r_dpos) begin
            sel_byte = r_txt[r_pos[TW-1:0]];
        end else if (r_pos < r_ppos) begin
            sel_byte = tla_pkg::CH_DOLLAR;
        end else if (r_pos < r_cpos) begin
            if (r_esc == tla_pkg::ESC_CARET || ridx == 2'd2) begin
                sel_byte = tla_pkg::CH_CARET;
            end else if (ridx == 2'd0) begin
                sel_byte = tla_pkg::CH_CAP_M;
            end else begin
                sel_byte = tla_pkg::CH_DASH;
            end
        end else begin
            sel_byte = r_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_mode <= '0;
            r_squeeze  <= 1'b0;
            r_ends     <= 1'b0;
            r_tabs     <= 1'b0;
            r_nonprint <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                tla_pkg::CFG_NUMBER_MODE:      r_num_mode <= i_cfg_wdata;
                tla_pkg::CFG_SQUEEZE_BLANK:    r_squeeze  <= i_cfg_wdata[0];
                tla_pkg::CFG_SHOW_ENDS:        r_ends     <= i_cfg_wdata[0];
                tla_pkg::CFG_SHOW_TABS:        r_tabs     <= i_cfg_wdata[0];
                tla_pkg::CFG_SHOW_NONPRINTING: r_nonprint <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_start  <= 1'b1;
            r_blank  <= '0;
            r_line   <= BW'(1);
            r_it_vld <= 1'b0;
            r_pos    <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (in_fire) begin
                r_prev   <= ch;
                r_start  <= 1'b0;
                r_blank  <= n_blank;
                if (do_num) begin
                    r_line <= n_line;
                end
                r_it_vld <= emit;
                r_pos    <= '0;
            end else if (adv) begin
                if (it_last) begin
                    r_it_vld <= 1'b0;
                end else begin
                    r_pos <= r_pos + PW'(1);
                end
            end
            if (adv) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_txt  <= n_txt;
            r_esc  <= esc;
            r_ch   <= fch;
            r_dpos <= n_dpos;
            r_ppos <= n_ppos;
            r_cpos <= n_cpos;
        end
        if (adv) begin
            r_ob <= sel_byte;
            r_ol <= it_last;
        end
    end

    assign o_out.valid    = r_ov;
    assign o_out.out_byte = r_ob;
    assign o_out.last     = r_ol;

endmodule

@@ hw/rtl/tla_checker.sv @@
module tla_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_byte) &&
                                           $stable(i_out_last)))
        else $error("stalled output word changed");

    // output register empties on reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // a run still pending and blocked downstream keeps the input closed
    a_run_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready && !i_out_last) |-> !i_in_ready)
        else $error("input open mid-run");

    // a run never has a bubble once started
    a_run_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_last) |=> i_out_valid)
        else $error("gap inside an output run");

endmodule

bind text_line_annotator tla_checker u_tla_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last)
);
